// ===== sv/software_timer_bank_macros.svh =====
// ----------------------------------------------------------------------------
// Software timer bank assertion macros
// Shared macros for the concurrent checks of the timer bank.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

// Checked on every clock edge outside reset.
`define SWTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SWTB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// Software timer bank package
// Codes, field widths and shared types of the timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

  localparam int ACTION_W  = 4;
  localparam int ID_W      = 4;
  localparam int TYPE_W    = 2;
  localparam int TIMEOUT_W = 32;
  localparam int STATUS_W  = 2;
  localparam int RSTATE_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int COUNT_MAX = 31;

  localparam logic [TYPE_W-1:0] TYPE_CYCLIC   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_ONE_SHOT = 2'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK         = 4'd0,
    ACT_SCAN         = 4'd1,
    ACT_REGISTER     = 4'd2,
    ACT_EDIT         = 4'd3,
    ACT_START        = 4'd4,
    ACT_STOP         = 4'd5,
    ACT_CONFIG_START = 4'd6,
    ACT_REMOVE       = 4'd7,
    ACT_QUERY        = 4'd8,
    ACT_START_ALL    = 4'd9,
    ACT_STOP_ALL     = 4'd10,
    ACT_REMOVE_ALL   = 4'd11,
    ACT_COUNT        = 4'd12
  } stb_action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_VALID = 2'd1,
    STAT_NO_FREE   = 2'd2
  } stb_status_e;

  typedef enum logic [RSTATE_W-1:0] {
    RS_STOPPED = 2'd0,
    RS_RUNNING = 2'd1,
    RS_EXPIRED = 2'd2,
    RS_REMOVE  = 2'd3
  } stb_run_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_PRIME,
    ST_SCAN,
    ST_WALK
  } stb_state_e;

  typedef struct packed {
    logic cyclic;
    logic timeout;
    logic start;
  } stb_wen_t;

endpackage

`default_nettype wire

// ===== sv/stb_if.sv =====
// ----------------------------------------------------------------------------
// Software timer bank channels
// Command and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface stb_cmd_if;
  import stb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [ID_W-1:0]      timer_id;
  logic [TYPE_W-1:0]    timer_type;
  logic [TIMEOUT_W-1:0] timeout;
  logic                 start_now;

  modport source (
    output valid, action, timer_id, timer_type, timeout, start_now,
    input  ready
  );
  modport sink (
    input  valid, action, timer_id, timer_type, timeout, start_now,
    output ready
  );
endinterface

interface stb_rsp_if;
  import stb_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     result_id;
  logic                fired;
  logic [RSTATE_W-1:0] run_state;
  logic [COUNT_W-1:0]  timer_count;

  modport source (
    output valid, status, result_id, fired, run_state, timer_count,
    input  ready
  );
  modport sink (
    input  valid, status, result_id, fired, run_state, timer_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/stb_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Software timer bank slot memory
// Type, timeout and start tick of every slot; one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_slot_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned TickW = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire                            clk_i,
  input  wire  stb_pkg::stb_wen_t        we_i,
  input  wire  [AddrW-1:0]               waddr_i,
  input  wire                            wcyclic_i,
  input  wire  [stb_pkg::TIMEOUT_W-1:0]  wtimeout_i,
  input  wire  [TickW-1:0]               wstart_i,
  input  wire  [AddrW-1:0]               raddr_i,
  output logic                           rcyclic_o,
  output logic [stb_pkg::TIMEOUT_W-1:0]  rtimeout_o,
  output logic [TickW-1:0]               rstart_o
);
  import stb_pkg::*;

  logic                 cyclic_mem  [Depth];
  logic [TIMEOUT_W-1:0] timeout_mem [Depth];
  logic [TickW-1:0]     start_mem   [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i.cyclic) begin
      cyclic_mem[waddr_i] <= wcyclic_i;
    end
    if (we_i.timeout) begin
      timeout_mem[waddr_i] <= wtimeout_i;
    end
    if (we_i.start) begin
      start_mem[waddr_i] <= wstart_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rcyclic_o  <= cyclic_mem[raddr_i];
    rtimeout_o <= timeout_mem[raddr_i];
    rstart_o   <= start_mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/stb_expiry_unit.sv =====
// ----------------------------------------------------------------------------
// Software timer bank expiry comparator
// Wrapped elapsed time of one slot compared against its timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_expiry_unit #(
  parameter int unsigned TickW = 32
) (
  input  wire  [TickW-1:0]              now_i,
  input  wire  [TickW-1:0]              start_i,
  input  wire  [stb_pkg::TIMEOUT_W-1:0] timeout_i,
  output logic                          expired_o
);
  import stb_pkg::*;

  localparam int unsigned CmpW = (TickW > TIMEOUT_W) ? TickW : TIMEOUT_W;

  logic [TickW-1:0] elapsed;

  assign elapsed   = now_i - start_i;
  assign expired_o = CmpW'(elapsed) > CmpW'(timeout_i);

endmodule

`default_nettype wire

// ===== sv/software_timer_bank.sv =====
// ----------------------------------------------------------------------------
// Software timer bank
// Bank of software timers driven by tick, scan and slot commands.
// ----------------------------------------------------------------------------
// The bank takes one command beat at a time and returns exactly one response
// beat for it; a new command is taken once the previous response has left.
// Tick, edit, start, stop, config-start, remove, query, stop-all, remove-all
// and unknown commands are carried out in the single execute state ST_EXEC.
// Scan goes through ST_SCAN_PRIME and ST_SCAN; register, start-all and count
// use ST_WALK. All of these walk the slots one per cycle; register and
// start-all write through the single write port of the slot memory, and scan
// reads via the single read port and checks with the one shared comparator.
// There is no clearing pass after reset; the bank is ready at once.
`default_nettype none

module software_timer_bank #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TICK_WIDTH = 32
) (
  input wire      clk_i,
  input wire      rst_ni,
  stb_cmd_if.sink cmd_i,
  stb_rsp_if.source rsp_o
);
  import stb_pkg::*;

`include "software_timer_bank_macros.svh"

  localparam int unsigned IdxW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CntW    = $clog2(NUM_TIMERS + 1);
  localparam int unsigned IdExtW  = (IdxW > ID_W) ? IdxW : ID_W;
  localparam int unsigned CntExtW = (CntW > COUNT_W) ? CntW : COUNT_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);

  stb_state_e           state_q, state_d;
  logic [TICK_WIDTH-1:0] now_q, now_d;
  logic [NUM_TIMERS-1:0] valid_q, valid_d;
  stb_run_e             rs_q [NUM_TIMERS];
  stb_run_e             rs_d [NUM_TIMERS];
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  stb_action_e          cmd_action_q;
  logic [ID_W-1:0]      cmd_id_q;
  logic [TYPE_W-1:0]    cmd_type_q;
  logic [TIMEOUT_W-1:0] cmd_timeout_q;
  logic                 cmd_start_now_q;

  stb_status_e          res_status_q, res_status_d;
  logic [ID_W-1:0]      res_id_q, res_id_d;
  logic                 res_fired_q, res_fired_d;
  logic [RSTATE_W-1:0]  res_rstate_q, res_rstate_d;
  logic [COUNT_W-1:0]   res_count_q, res_count_d;

  logic                 cmd_accept;
  logic                 finish;
  logic [IdExtW-1:0]    id_ext;
  logic [IdxW-1:0]      slot;
  logic                 id_ok;
  logic [IdExtW-1:0]    idx_ext;
  logic [CntW-1:0]      cnt_sum;
  logic [CntExtW-1:0]   cnt_ext;
  logic [COUNT_W-1:0]   cnt_sat;

  stb_wen_t             wen;
  logic [IdxW-1:0]      waddr;
  logic [IdxW-1:0]      raddr;
  logic                 rd_cyclic;
  logic [TIMEOUT_W-1:0] rd_timeout;
  logic [TICK_WIDTH-1:0] rd_start;
  logic                 expired;

  assign cmd_accept = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && !out_valid_q;

  assign id_ext  = IdExtW'(cmd_id_q);
  assign slot    = id_ext[IdxW-1:0];
  assign id_ok   = (32'(cmd_id_q) < 32'(NUM_TIMERS)) && valid_q[slot];
  assign idx_ext = IdExtW'(idx_q);
  assign cnt_sum = cnt_q + CntW'(valid_q[idx_q]);
  assign cnt_ext = CntExtW'(cnt_sum);
  assign cnt_sat = (cnt_ext > CntExtW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                   : cnt_ext[COUNT_W-1:0];

  assign waddr = (state_q == ST_EXEC) ? slot : idx_q;
  assign raddr = (state_q == ST_SCAN_PRIME) ? '0 : IdxW'(idx_q + 1'b1);

  stb_slot_ram #(
    .Depth (NUM_TIMERS),
    .TickW (TICK_WIDTH),
    .AddrW (IdxW)
  ) u_slot_ram (
    .clk_i      (clk_i),
    .we_i       (wen),
    .waddr_i    (waddr),
    .wcyclic_i  (cmd_type_q == TYPE_CYCLIC),
    .wtimeout_i (cmd_timeout_q),
    .wstart_i   (now_q),
    .raddr_i    (raddr),
    .rcyclic_o  (rd_cyclic),
    .rtimeout_o (rd_timeout),
    .rstart_o   (rd_start)
  );

  stb_expiry_unit #(
    .TickW (TICK_WIDTH)
  ) u_expiry (
    .now_i     (now_q),
    .start_i   (rd_start),
    .timeout_i (rd_timeout),
    .expired_o (expired)
  );

  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    valid_d      = valid_q;
    rs_d         = rs_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    wen          = '0;
    finish       = 1'b0;
    res_status_d = STAT_OK;
    res_id_d     = '0;
    res_fired_d  = 1'b0;
    res_rstate_d = '0;
    res_count_d  = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_accept) begin
          idx_d = '0;
          cnt_d = '0;
          case (stb_action_e'(cmd_i.action))
            ACT_SCAN: state_d = ST_SCAN_PRIME;
            ACT_REGISTER, ACT_START_ALL, ACT_COUNT: state_d = ST_WALK;
            default: state_d = ST_EXEC;
          endcase
        end
      end

      ST_EXEC: begin
        finish = 1'b1;
        unique case (cmd_action_q)
          ACT_TICK: now_d = now_q + TICK_WIDTH'(1);
          ACT_EDIT: begin
            if (!id_ok) begin
              res_status_d = STAT_NOT_VALID;
            end else begin
              wen.cyclic  = (cmd_type_q == TYPE_CYCLIC) || (cmd_type_q == TYPE_ONE_SHOT);
              wen.timeout = (cmd_timeout_q != '0);
            end
          end
          ACT_START: begin
            if (!id_ok) begin
              res_status_d = STAT_NOT_VALID;
            end else begin
              rs_d[slot] = RS_RUNNING;
              wen.start  = 1'b1;
            end
          end
          ACT_STOP: begin
            if (!id_ok) begin
              res_status_d = STAT_NOT_VALID;
            end else begin
              rs_d[slot] = RS_STOPPED;
            end
          end
          ACT_CONFIG_START: begin
            if (!id_ok) begin
              res_status_d = STAT_NOT_VALID;
            end else begin
              rs_d[slot] = RS_RUNNING;
              wen        = '{cyclic: 1'b1, timeout: 1'b1, start: 1'b1};
            end
          end
          ACT_REMOVE: begin
            if (!id_ok) begin
              res_status_d = STAT_NOT_VALID;
            end else begin
              rs_d[slot] = RS_REMOVE;
            end
          end
          ACT_QUERY: begin
            if (!id_ok) begin
              res_status_d = STAT_NOT_VALID;
            end else begin
              res_rstate_d = rs_q[slot];
            end
          end
          ACT_STOP_ALL, ACT_REMOVE_ALL: begin
            for (int i = 0; i < int'(NUM_TIMERS); i++) begin
              if (valid_q[i]) begin
                rs_d[i] = (cmd_action_q == ACT_STOP_ALL) ? RS_STOPPED : RS_REMOVE;
              end
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN_PRIME: begin
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        if (valid_q[idx_q] && (rs_q[idx_q] == RS_RUNNING) && expired) begin
          if (rd_cyclic) begin
            wen.start = 1'b1;
          end else begin
            rs_d[idx_q] = RS_EXPIRED;
          end
          res_fired_d = 1'b1;
          res_id_d    = idx_ext[ID_W-1:0];
          finish      = 1'b1;
        end else begin
          if (valid_q[idx_q] && (rs_q[idx_q] == RS_REMOVE)) begin
            valid_d[idx_q] = 1'b0;
            rs_d[idx_q]    = RS_STOPPED;
          end
          if (idx_q == LastIdx) begin
            finish = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      ST_WALK: begin
        if (idx_q != LastIdx) begin
          idx_d = idx_q + 1'b1;
        end
        case (cmd_action_q)
          ACT_REGISTER: begin
            if (!valid_q[idx_q]) begin
              valid_d[idx_q] = 1'b1;
              rs_d[idx_q]    = cmd_start_now_q ? RS_RUNNING : RS_STOPPED;
              wen            = '{cyclic: 1'b1, timeout: 1'b1, start: 1'b1};
              res_id_d       = idx_ext[ID_W-1:0];
              finish         = 1'b1;
            end else if (idx_q == LastIdx) begin
              res_status_d = STAT_NO_FREE;
              finish       = 1'b1;
            end
          end
          ACT_START_ALL: begin
            if (valid_q[idx_q]) begin
              rs_d[idx_q] = RS_RUNNING;
              wen.start   = 1'b1;
            end
            finish = (idx_q == LastIdx);
          end
          ACT_COUNT: begin
            cnt_d       = cnt_sum;
            res_count_d = cnt_sat;
            finish      = (idx_q == LastIdx);
          end
          default: finish = 1'b1;
        endcase
      end

      default: state_d = ST_IDLE;
    endcase

    if (finish) begin
      out_valid_d = 1'b1;
      state_d     = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      valid_q     <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(NUM_TIMERS); i++) begin
        rs_q[i] <= RS_STOPPED;
      end
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      valid_q     <= valid_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      rs_q        <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      cmd_action_q    <= stb_action_e'(cmd_i.action);
      cmd_id_q        <= cmd_i.timer_id;
      cmd_type_q      <= cmd_i.timer_type;
      cmd_timeout_q   <= cmd_i.timeout;
      cmd_start_now_q <= cmd_i.start_now;
    end
    if (finish) begin
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_fired_q  <= res_fired_d;
      res_rstate_q <= res_rstate_d;
      res_count_q  <= res_count_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = res_status_q;
  assign rsp_o.result_id   = res_id_q;
  assign rsp_o.fired       = res_fired_q;
  assign rsp_o.run_state   = res_rstate_q;
  assign rsp_o.timer_count = res_count_q;

  `SWTB_ASSERT(a_busy_after_accept, cmd_accept |=> !cmd_i.ready, "Command taken while busy.")
  `SWTB_ASSERT(a_no_work_while_full, state_q != ST_IDLE |-> !out_valid_q, "Sequencer ran with a pending response.")
  `SWTB_ASSERT_ALWAYS(a_ram_write_busy, (wen.cyclic || wen.timeout || wen.start) |-> state_q != ST_IDLE, "Slot memory written while idle.")
  `SWTB_ASSERT(a_fire_clean, out_valid_q && res_fired_q |-> res_status_q == STAT_OK && res_count_q == '0 && res_rstate_q == '0, "Fired response carries other fields.")
  `SWTB_ASSERT(a_result_from_work, $rose(out_valid_q) |-> $past(state_q) != ST_IDLE, "Response raised without a finished command.")

endmodule

`default_nettype wire
